// File: design/bes_pkg.sv
// ----------------------------------------------------------------------------
// bes_pkg
// Shared types and constants of the bilinear equirect sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bes_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 128;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WREG_W  = 9;
  localparam int HREG_W  = 8;
  localparam int CH_W    = 24;
  localparam int NUM_CH  = 3;
  localparam int TEXEL_W = CH_W * NUM_CH;
  localparam int FRAC_W  = 16;
  localparam int COORD_W = 24;

  // four banks split by row and column parity
  localparam int NUM_BANKS  = 4;
  localparam int BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / NUM_BANKS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // lerp arithmetic widths
  localparam int DIFF_W = CH_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_W + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(MAX_WIDTH);
  localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(MAX_HEIGHT);
  localparam logic [FRAC_W:0]   ONE_Q16      = (FRAC_W+1)'(1 << FRAC_W);

  // classified item handed from the front end to the texel back end
  typedef struct packed {
    logic                 is_write;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic [TEXEL_W-1:0]   texel;
    logic [COL_W-1:0]     i0;
    logic [COL_W-1:0]     i1;
    logic [ROW_W-1:0]     j0;
    logic [ROW_W-1:0]     j1;
    logic [FRAC_W-1:0]    tx;
    logic [FRAC_W-1:0]    ty;
  } bes_item_t;

endpackage

`default_nettype wire

// File: design/bes_ram.sv
// ----------------------------------------------------------------------------
// bes_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bes_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/bes_front.sv
// ----------------------------------------------------------------------------
// bes_front
// Accepts items, holds the size registers and turns sample coordinates
// into texel indices and fractions.
// ----------------------------------------------------------------------------
`default_nettype none

module bes_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire logic                            mode_i,
  input  wire logic [bes_pkg::COL_W-1:0]       texel_col_i,
  input  wire logic [bes_pkg::ROW_W-1:0]       texel_row_i,
  input  wire logic [bes_pkg::TEXEL_W-1:0]     texel_i,
  input  wire logic signed [bes_pkg::COORD_W-1:0] u_coord_i,
  input  wire logic signed [bes_pkg::COORD_W-1:0] v_coord_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [bes_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bes_pkg::WREG_W-1:0]      cfg_data_i,
  output logic                                 push_o,
  output bes_pkg::bes_item_t                   item_o
);
  import bes_pkg::*;

  logic [WREG_W-1:0] width_q;
  logic [HREG_W-1:0] height_q;

  // size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i[HREG_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 0: capture the accepted item
  logic                   s0_v_q;
  logic                   s0_write_q;
  logic [COL_W-1:0]       s0_col_q;
  logic [ROW_W-1:0]       s0_row_q;
  logic [TEXEL_W-1:0]     s0_texel_q;
  logic [FRAC_W-1:0]      s0_u_q;
  logic signed [COORD_W-1:0] s0_v_coord_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else begin
      s0_v_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s0_write_q   <= ~mode_i;
      s0_col_q     <= texel_col_i;
      s0_row_q     <= texel_row_i;
      s0_texel_q   <= texel_i;
      s0_u_q       <= u_coord_i[FRAC_W-1:0];
      s0_v_coord_q <= v_coord_i;
    end
  end

  // clamp sizes to 1..max and form size minus one
  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;

  always_comb begin
    priority if (width_q == '0) w_m1 = '0;
    else if (width_q > WREG_W'(MAX_WIDTH)) w_m1 = COL_W'(MAX_WIDTH - 1);
    else w_m1 = COL_W'(width_q - WREG_W'(1));
    priority if (height_q == '0) h_m1 = '0;
    else if (height_q > HREG_W'(MAX_HEIGHT)) h_m1 = ROW_W'(MAX_HEIGHT - 1);
    else h_m1 = ROW_W'(height_q - HREG_W'(1));
  end

  // clamp v to [0, 1.0]
  logic [FRAC_W:0] vv;
  logic [FRAC_W:0] one_minus_v;

  always_comb begin
    priority if (s0_v_coord_q < 0) vv = '0;
    else if (s0_v_coord_q > $signed(COORD_W'(ONE_Q16))) vv = ONE_Q16;
    else vv = s0_v_coord_q[FRAC_W:0];
    one_minus_v = ONE_Q16 - vv;
  end

  // stage 1: scaled coordinates
  logic                       s1_v_q;
  logic                       s1_write_q;
  logic [COL_W-1:0]           s1_col_q;
  logic [ROW_W-1:0]           s1_row_q;
  logic [TEXEL_W-1:0]         s1_texel_q;
  logic [FRAC_W+COL_W-1:0]    s1_fx_q;
  logic [FRAC_W+ROW_W:0]      s1_fy_q;
  logic [COL_W-1:0]           s1_w_m1_q;
  logic [ROW_W-1:0]           s1_h_m1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_v_q) begin
      s1_write_q <= s0_write_q;
      s1_col_q   <= s0_col_q;
      s1_row_q   <= s0_row_q;
      s1_texel_q <= s0_texel_q;
      s1_fx_q    <= (FRAC_W+COL_W)'(s0_u_q * w_m1);
      s1_fy_q    <= (FRAC_W+ROW_W+1)'(one_minus_v * h_m1);
      s1_w_m1_q  <= w_m1;
      s1_h_m1_q  <= h_m1;
    end
  end

  // split into indices and fractions, clamp neighbors
  logic [COL_W-1:0] i0_raw, i0, i1;
  logic [ROW_W:0]   j0_raw;
  logic [ROW_W-1:0] j0, j1;

  always_comb begin
    i0_raw = s1_fx_q[FRAC_W +: COL_W];
    j0_raw = s1_fy_q[FRAC_W +: ROW_W+1];
    i0 = (i0_raw > s1_w_m1_q) ? s1_w_m1_q : i0_raw;
    j0 = (j0_raw > {1'b0, s1_h_m1_q}) ? s1_h_m1_q : j0_raw[ROW_W-1:0];
    i1 = (i0 < s1_w_m1_q) ? COL_W'(i0 + COL_W'(1)) : s1_w_m1_q;
    j1 = (j0 < s1_h_m1_q) ? ROW_W'(j0 + ROW_W'(1)) : s1_h_m1_q;
  end

  assign push_o = s1_v_q;

  always_comb begin
    item_o          = '0;
    item_o.is_write = s1_write_q;
    item_o.row      = s1_row_q;
    item_o.col      = s1_col_q;
    item_o.texel    = s1_texel_q;
    item_o.i0       = i0;
    item_o.i1       = i1;
    item_o.j0       = j0;
    item_o.j1       = j1;
    item_o.tx       = s1_fx_q[FRAC_W-1:0];
    item_o.ty       = s1_fy_q[FRAC_W-1:0];
  end

endmodule

`default_nettype wire

// File: design/bes_queue.sv
// ----------------------------------------------------------------------------
// bes_queue
// Two-entry queue between the front end and the texel back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bes_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire bes_pkg::bes_item_t push_item_i,
  input  wire logic               pop_i,
  output logic                    head_valid_o,
  output bes_pkg::bes_item_t      head_item_o,
  output logic                    full_o
);
  import bes_pkg::*;

  bes_item_t  slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_pop;

  assign do_pop       = pop_i && (count_q != 2'd0);
  assign head_valid_o = (count_q != 2'd0);
  assign head_item_o  = slot_q[rd_ptr_q];
  assign full_o       = (count_q == 2'd2);

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= 2'(count_q + {1'b0, push_i} - {1'b0, do_pop});
    end
  end

  // store pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// File: design/bes_back.sv
// ----------------------------------------------------------------------------
// bes_back
// Writes texels into four parity banks, reads the four neighbors of a
// sample at once and blends them in a fixed-latency pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module bes_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        head_valid_i,
  input  wire bes_pkg::bes_item_t          head_item_i,
  output logic                             pop_o,
  output logic                             result_valid_o,
  output logic [bes_pkg::TEXEL_W-1:0]      result_o
);
  import bes_pkg::*;

  // never stall: take the head whenever there is one
  assign pop_o = head_valid_i;

  logic rd_go;
  logic wr_go;
  assign rd_go = head_valid_i && !head_item_i.is_write;
  assign wr_go = head_valid_i && head_item_i.is_write &&
                 ({1'b0, head_item_i.col} < (COL_W+1)'(MAX_WIDTH)) &&
                 ({1'b0, head_item_i.row} < (ROW_W+1)'(MAX_HEIGHT));

  // one bank per row/column parity
  logic [TEXEL_W-1:0] bank_rdata [NUM_BANKS];

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic             rp, cp;
    logic [ROW_W-1:0] rsel;
    logic [COL_W-1:0] csel;
    logic             we;

    assign rp   = 1'(b >> 1);
    assign cp   = 1'(b);
    assign rsel = (head_item_i.j0[0] == rp) ? head_item_i.j0 : head_item_i.j1;
    assign csel = (head_item_i.i0[0] == cp) ? head_item_i.i0 : head_item_i.i1;
    assign we   = wr_go && (head_item_i.row[0] == rp) && (head_item_i.col[0] == cp);

    bes_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i ({head_item_i.row[ROW_W-1:1], head_item_i.col[COL_W-1:1]}),
      .wdata_i (head_item_i.texel),
      .re_i    (rd_go),
      .raddr_i ({rsel[ROW_W-1:1], csel[COL_W-1:1]}),
      .rdata_o (bank_rdata[b])
    );
  end

  // stage 1: bank data arrives, keep selectors and fractions alongside
  logic              b1_v_q;
  logic [1:0]        sel00_q, sel10_q, sel01_q, sel11_q;
  logic [FRAC_W-1:0] b1_tx_q, b1_ty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
    end else begin
      b1_v_q <= rd_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_go) begin
      sel00_q <= {head_item_i.j0[0], head_item_i.i0[0]};
      sel10_q <= {head_item_i.j0[0], head_item_i.i1[0]};
      sel01_q <= {head_item_i.j1[0], head_item_i.i0[0]};
      sel11_q <= {head_item_i.j1[0], head_item_i.i1[0]};
      b1_tx_q <= head_item_i.tx;
      b1_ty_q <= head_item_i.ty;
    end
  end

  logic [TEXEL_W-1:0] c00, c10, c01, c11;
  assign c00 = bank_rdata[sel00_q];
  assign c10 = bank_rdata[sel10_q];
  assign c01 = bank_rdata[sel01_q];
  assign c11 = bank_rdata[sel11_q];

  // stage 2: x-direction products, lerp as a + ((b - a) * t) >> 16
  logic                     b2_v_q;
  logic [CH_W-1:0]          b2_a0_q [NUM_CH];
  logic [CH_W-1:0]          b2_a1_q [NUM_CH];
  logic signed [PROD_W-1:0] b2_p0_q [NUM_CH];
  logic signed [PROD_W-1:0] b2_p1_q [NUM_CH];
  logic [FRAC_W-1:0]        b2_ty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_v_q <= 1'b0;
    end else begin
      b2_v_q <= b1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_v_q) begin
      for (int c = 0; c < NUM_CH; c++) begin
        b2_a0_q[c] <= c00[c*CH_W +: CH_W];
        b2_a1_q[c] <= c01[c*CH_W +: CH_W];
        b2_p0_q[c] <= ($signed({1'b0, c10[c*CH_W +: CH_W]}) -
                       $signed({1'b0, c00[c*CH_W +: CH_W]})) *
                      $signed({1'b0, b1_tx_q});
        b2_p1_q[c] <= ($signed({1'b0, c11[c*CH_W +: CH_W]}) -
                       $signed({1'b0, c01[c*CH_W +: CH_W]})) *
                      $signed({1'b0, b1_tx_q});
      end
      b2_ty_q <= b1_ty_q;
    end
  end

  // stage 3: finish x lerps
  logic              b3_v_q;
  logic [CH_W-1:0]   b3_r0_q [NUM_CH];
  logic [CH_W-1:0]   b3_r1_q [NUM_CH];
  logic [FRAC_W-1:0] b3_ty_q;
  logic signed [PROD_W-1:0] sum0 [NUM_CH];
  logic signed [PROD_W-1:0] sum1 [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum0[c] = $signed({2'b00, b2_a0_q[c], {FRAC_W{1'b0}}}) + b2_p0_q[c];
      sum1[c] = $signed({2'b00, b2_a1_q[c], {FRAC_W{1'b0}}}) + b2_p1_q[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b3_v_q <= 1'b0;
    end else begin
      b3_v_q <= b2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b2_v_q) begin
      for (int c = 0; c < NUM_CH; c++) begin
        b3_r0_q[c] <= sum0[c][FRAC_W +: CH_W];
        b3_r1_q[c] <= sum1[c][FRAC_W +: CH_W];
      end
      b3_ty_q <= b2_ty_q;
    end
  end

  // stage 4: y-direction product
  logic                     b4_v_q;
  logic [CH_W-1:0]          b4_a_q [NUM_CH];
  logic signed [PROD_W-1:0] b4_p_q [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b4_v_q <= 1'b0;
    end else begin
      b4_v_q <= b3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b3_v_q) begin
      for (int c = 0; c < NUM_CH; c++) begin
        b4_a_q[c] <= b3_r0_q[c];
        b4_p_q[c] <= ($signed({1'b0, b3_r1_q[c]}) - $signed({1'b0, b3_r0_q[c]})) *
                     $signed({1'b0, b3_ty_q});
      end
    end
  end

  // output register
  logic                     out_v_q;
  logic [TEXEL_W-1:0]       out_q;
  logic signed [PROD_W-1:0] sumy [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sumy[c] = $signed({2'b00, b4_a_q[c], {FRAC_W{1'b0}}}) + b4_p_q[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= b4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b4_v_q) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_q[c*CH_W +: CH_W] <= sumy[c][FRAC_W +: CH_W];
      end
    end
  end

  assign result_valid_o = out_v_q;
  assign result_o       = out_q;

`ifndef ASSERT_OFF
  a_read_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b1_v_q |-> $past(head_valid_i && !head_item_i.is_write))
    else $error("bank read started without a sample item");
  a_write_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_i && head_item_i.is_write) |=> !b1_v_q)
    else $error("texel write entered the blend pipeline");
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(rd_go, 5))
    else $error("result without a sample five cycles earlier");
`endif

endmodule

`default_nettype wire

// File: design/bilinear_equirect_sample.sv
// ----------------------------------------------------------------------------
// bilinear_equirect_sample
// Bilinear RGB texture sampler with wrapped u and clamped v.
// ----------------------------------------------------------------------------
// The block takes one item per clock: a texel write (mode 0) or a sample
// request (mode 1). A sample result is on the result ports for one cycle,
// after passing two front stages, the queue, the bank read, three blend
// stages and the output register; writes give no result. The rate is set
// by the four parity banks of the texel store, which return all four
// neighbors of a sample in a single read, so busy never rises and the
// receiver cannot stall. A sample sees every write accepted before it.
// The user must write the size registers through the cfg port only while
// no item is in flight; the block itself does not enforce this.
`default_nettype none

module bilinear_equirect_sample (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   mode_i,
  input  wire logic [7:0]             texel_col_i,
  input  wire logic [6:0]             texel_row_i,
  input  wire logic [23:0]            red_in_i,
  input  wire logic [23:0]            green_in_i,
  input  wire logic [23:0]            blue_in_i,
  input  wire logic signed [23:0]     u_coord_i,
  input  wire logic signed [23:0]     v_coord_i,
  output logic                        result_valid_o,
  output logic [23:0]                 red_out_o,
  output logic [23:0]                 green_out_o,
  output logic [23:0]                 blue_out_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [bes_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bes_pkg::WREG_W-1:0]    cfg_data_i
);
  import bes_pkg::*;

  logic               accept;
  logic               push;
  bes_item_t          push_item;
  logic               head_valid;
  bes_item_t          head_item;
  logic               pop;
  logic               queue_full;
  logic [TEXEL_W-1:0] result;

  assign busy        = queue_full;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  bes_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .texel_col_i (texel_col_i),
    .texel_row_i (texel_row_i),
    .texel_i     ({blue_in_i, green_in_i, red_in_i}),
    .u_coord_i   (u_coord_i),
    .v_coord_i   (v_coord_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .item_o      (push_item)
  );

  bes_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item),
    .full_o       (queue_full)
  );

  bes_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_item_i    (head_item),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result)
  );

  assign red_out_o   = result[0*CH_W +: CH_W];
  assign green_out_o = result[1*CH_W +: CH_W];
  assign blue_out_o  = result[2*CH_W +: CH_W];

endmodule

`default_nettype wire

// File: test/bilinear_equirect_sample_tb.sv
// ----------------------------------------------------------------------------
// bilinear_equirect_sample_tb
// Self-checking regression of the bilinear equirect sampler.
// ----------------------------------------------------------------------------
// Loads textures texel by texel, sets the size registers to several values
// and samples at directed and random coordinates. A local predictor of the
// filter computes each expected color, and a checker compares every result
// strobe against the oldest pending prediction.
`timescale 1ns / 100ps
`default_nettype none

module bilinear_equirect_sample_tb;
  import bes_pkg::*;

  localparam int LATENCY = 8;
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } color_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic mode_i = 1'b0;
  logic [7:0] texel_col_i = '0;
  logic [6:0] texel_row_i = '0;
  logic [23:0] red_in_i = '0, green_in_i = '0, blue_in_i = '0;
  logic signed [23:0] u_coord_i = '0, v_coord_i = '0;
  logic result_valid_o;
  logic [23:0] red_out_o, green_out_o, blue_out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [WREG_W-1:0] cfg_data_i = '0;

  // predictor state
  color_t texture [MAX_WIDTH*MAX_HEIGHT];
  bit written [MAX_WIDTH*MAX_HEIGHT];
  int unsigned width_reg = MAX_WIDTH;
  int unsigned height_reg = MAX_HEIGHT;
  color_t expected_colors[$];
  int errors = 0;

  bilinear_equirect_sample i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("bilinear_equirect_sample regression: fail");
    $finish;
  end

  function automatic int unsigned eff_size(int unsigned r, int unsigned m);
    if (r == 0) return 1;
    if (r > m) return m;
    return r;
  endfunction

  function automatic logic [CH_W-1:0] lerp(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                           int unsigned t);
    longint unsigned mix;
    mix = (64'(a) * (64'd65536 - 64'(t)) + 64'(b) * 64'(t)) >> 16;
    return CH_W'(mix);
  endfunction

  // texel indices and fractions of one sample
  function automatic void find_neighbors(logic [23:0] u, logic signed [23:0] v,
                                         output int unsigned i0, i1, j0, j1, tx, ty);
    int unsigned w, h, vv;
    longint unsigned fx, fy;
    w = eff_size(width_reg, MAX_WIDTH);
    h = eff_size(height_reg, MAX_HEIGHT);
    if (v < 0) vv = 0;
    else if (v > 65536) vv = 65536;
    else vv = {8'h00, v};
    fx = 64'(u[15:0]) * 64'(w - 1);
    fy = 64'(65536 - vv) * 64'(h - 1);
    i0 = 32'(fx >> 16); j0 = 32'(fy >> 16);
    tx = 32'(fx & 64'hFFFF); ty = 32'(fy & 64'hFFFF);
    if (i0 > w - 1) i0 = w - 1;
    if (j0 > h - 1) j0 = h - 1;
    i1 = (i0 + 1 < w) ? i0 + 1 : w - 1;
    j1 = (j0 + 1 < h) ? j0 + 1 : h - 1;
  endfunction

  // filter one sample from the local copy of the texture
  function automatic color_t filter_sample(logic [23:0] u, logic signed [23:0] v);
    int unsigned i0, i1, j0, j1, tx, ty;
    color_t c00, c10, c01, c11, res;
    find_neighbors(u, v, i0, i1, j0, j1, tx, ty);
    c00 = texture[j0*MAX_WIDTH+i0]; c10 = texture[j0*MAX_WIDTH+i1];
    c01 = texture[j1*MAX_WIDTH+i0]; c11 = texture[j1*MAX_WIDTH+i1];
    res.red = lerp(lerp(c00.red, c10.red, tx), lerp(c01.red, c11.red, tx), ty);
    res.green = lerp(lerp(c00.green, c10.green, tx), lerp(c01.green, c11.green, tx), ty);
    res.blue = lerp(lerp(c00.blue, c10.blue, tx), lerp(c01.blue, c11.blue, tx), ty);
    return res;
  endfunction

  function automatic color_t rand_color();
    return color_t'({24'($urandom), 24'($urandom), 24'($urandom)});
  endfunction

  // send one item, waiting for acceptance
  task automatic send_item(logic m, logic [7:0] col, logic [6:0] row, color_t c,
                           logic [23:0] u, logic [23:0] v);
    start <= 1'b1; mode_i <= m;
    texel_col_i <= col; texel_row_i <= row;
    red_in_i <= c.red; green_in_i <= c.green; blue_in_i <= c.blue;
    u_coord_i <= u; v_coord_i <= v;
    do @(posedge clk_i); while (busy);
    if (m == MODE_WRITE) begin
      texture[row*MAX_WIDTH+col] = c;
      written[row*MAX_WIDTH+col] = 1'b1;
    end else begin
      expected_colors.push_back(filter_sample(u, v));
    end
  endtask

  // now and then end an item stream, with a random gap before the next
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic write_texel(int col, int row, color_t c);
    send_item(MODE_WRITE, 8'(col), 7'(row), c, 24'($urandom), 24'($urandom));
  endtask

  // sample, flagging an error unless all four neighbors hold written texels
  task automatic sample(logic [23:0] u, logic [23:0] v);
    int unsigned i0, i1, j0, j1, tx, ty;
    find_neighbors(u, v, i0, i1, j0, j1, tx, ty);
    if (!(written[j0*MAX_WIDTH+i0] && written[j0*MAX_WIDTH+i1] &&
          written[j1*MAX_WIDTH+i0] && written[j1*MAX_WIDTH+i1])) begin
      $display("%0t: sample at u %h v %h reads an unwritten texel", $time, u, v);
      errors++;
    end
    send_item(MODE_SAMPLE, 8'($urandom), 7'($urandom), rand_color(), u, v);
  endtask

  // write the four neighbors of a sample, then take the sample
  task automatic sample_loaded(logic [23:0] u, logic [23:0] v);
    int unsigned i0, i1, j0, j1, tx, ty;
    find_neighbors(u, v, i0, i1, j0, j1, tx, ty);
    write_texel(i0, j0, rand_color());
    write_texel(i1, j0, rand_color());
    write_texel(i0, j1, rand_color());
    write_texel(i1, j1, rand_color());
    sample(u, v);
  endtask

  // wait for all results, then settle so a write is not in flight
  task automatic drain();
    start <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= WREG_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_WIDTH) width_reg = val & 32'h1FF;
    else if (idx == CFG_HEIGHT) height_reg = val & 32'hFF;
    @(posedge clk_i);
  endtask

  // load the whole used area so no sample reads an unwritten texel
  task automatic load_texture(int unsigned w, int unsigned h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        write_texel(c, r, rand_color());
        if ($urandom_range(0, 15) == 0) idle_gap();
      end
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 65536));
      2: return {8'h00, 16'($urandom)};
      default: return {$urandom_range(0, 1) ? 8'hFF : 8'h01, 16'($urandom)};
    endcase
  endfunction

  task automatic test_directed();
    color_t c;
    write_reg(CFG_WIDTH, 4);
    write_reg(CFG_HEIGHT, 3);
    c = '1; write_texel(0, 0, c);
    c = '0; write_texel(1, 0, c);
    write_texel(255, 127, color_t'({24'hFFFFFF, 24'h0, 24'h123456}));
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 4; k++)
        write_texel(k, r, rand_color());
    sample(24'h000000, 24'h000000);
    sample(24'h00FFFF, 24'h010000);
    sample(24'h800000, 24'h7FFFFF);
    sample(24'h7FFFFF, 24'h800000);
    sample(24'hFF8000, 24'hFFFFFF);
    sample(24'h008000, 24'h008000);
    sample(24'h010000, 24'h010001);
    sample(24'hFFFFFF, 24'h00FFFF);
    drain();
  endtask

  task automatic test_sizes();
    int unsigned sizes [6][2] = '{'{0, 0}, '{1, 1}, '{511, 255}, '{2, 2},
                                  '{257, 129}, '{7, 5}};
    foreach (sizes[k]) begin
      write_reg(CFG_WIDTH, sizes[k][0]);
      write_reg(CFG_HEIGHT, sizes[k][1]);
      repeat (6) sample_loaded(rand_coord(), rand_coord());
      drain();
    end
  endtask

  task automatic test_random();
    int unsigned w, h;
    for (int phase = 0; phase < 4; phase++) begin
      w = $urandom_range(1, 8); h = $urandom_range(1, 8);
      write_reg(CFG_WIDTH, w);
      write_reg(CFG_HEIGHT, h);
      load_texture(w, h);
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(0, 4) == 0)
          write_texel($urandom_range(0, w - 1), $urandom_range(0, h - 1), rand_color());
        else
          sample(rand_coord(), rand_coord());
        if ($urandom_range(0, 7) == 0) idle_gap();
      end
      drain();
    end
  endtask

  // compare each result strobe with the oldest prediction
  always @(posedge clk_i) begin
    color_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected result %h %h %h", $time,
                 red_out_o, green_out_o, blue_out_o);
        errors++;
      end else begin
        want = expected_colors.pop_front();
        if (red_out_o !== want.red) begin
          $display("%0t: red expected %h actual %h", $time, want.red, red_out_o);
          errors++;
        end
        if (green_out_o !== want.green) begin
          $display("%0t: green expected %h actual %h", $time, want.green, green_out_o);
          errors++;
        end
        if (blue_out_o !== want.blue) begin
          $display("%0t: blue expected %h actual %h", $time, want.blue, blue_out_o);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_sizes();
    test_random();
    drain();
    if (errors == 0 && expected_colors.size() == 0) begin
      $display("bilinear_equirect_sample regression: pass");
    end else begin
      $display("bilinear_equirect_sample regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
